FILE: sv/fccd_pkg.sv
// Shared types, constants and register codes for the frame colour change detector.
`default_nettype none

package fccd_pkg;

    localparam int COLOR_W               = 8;
    localparam int WF_W                  = 7;
    localparam int THR_W                 = 16;
    localparam int Q_FRAC                = 8;
    localparam int CFG_IDX_W             = 1;
    localparam int CFG_DATA_W            = 16;
    localparam int DEF_MAX_WINDOW        = 64;
    localparam int DEF_FRAME_PIXELS_LOG2 = 22;
    localparam int DEF_WINDOW_FRAMES     = 8;
    localparam int DEF_THRESHOLD_Q       = 256;
    localparam int MIN_WINDOW            = 2;
    localparam int CALC_LAT              = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_Q   = 1'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               frame_end;
    } pix_in_t;

    typedef struct packed {
        logic light_on;
        logic window_full;
    } result_t;

    typedef struct packed {
        logic pixel;
        logic frame_end;
        logic clear;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic full_now;
        logic sweep_busy;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/fccd_dp.sv
// Datapath: frame sums, ring of frame sums, window sweep, threshold arithmetic and result register.
`default_nettype none

module fccd_dp #(
    parameter int MAX_WINDOW        = fccd_pkg::DEF_MAX_WINDOW,
    parameter int FRAME_PIXELS_LOG2 = fccd_pkg::DEF_FRAME_PIXELS_LOG2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    input  logic [fccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fccd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  fccd_pkg::pix_in_t               s_data,
    input  fccd_pkg::dp_cmd_t               dp_cmd,
    output fccd_pkg::dp_stat_t              dp_stat,
    input  logic                            m_ready,
    output logic                            m_valid,
    output fccd_pkg::result_t               m_data
);
    import fccd_pkg::*;

    localparam int ACC_W  = FRAME_PIXELS_LOG2 + COLOR_W;
    localparam int IDX_W  = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int WCMP_W = (CNT_W > WF_W) ? CNT_W : WF_W;
    localparam int ENT_W  = 3 * ACC_W;
    localparam int OLD_W  = ACC_W + IDX_W;
    localparam int DW     = OLD_W + 1;
    localparam int SW     = DW + 1;
    localparam int TW     = DW + 2;
    localparam int LO_W   = SW / 2;
    localparam int HI_W   = SW - LO_W;
    localparam int PLO_W  = THR_W + LO_W + 1;
    localparam int PHI_W  = THR_W + HI_W;
    localparam int CW     = SW + THR_W;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                  input logic [COLOR_W-1:0] v);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + (ACC_W + 1)'(v);
        return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
    endfunction

    logic        [WF_W-1:0]   wf_reg;
    logic signed [THR_W-1:0]  thr_reg;
    logic        [ACC_W-1:0]  red_acc_reg, green_acc_reg, blue_acc_reg;
    logic        [ACC_W-1:0]  red_next, green_next, blue_next;
    logic        [IDX_W-1:0]  head_reg, head_next;
    logic        [CNT_W-1:0]  fill_reg, fill_next;
    logic        [CNT_W:0]    fill_inc;
    logic        [WCMP_W-1:0] wf_ext;
    logic        [CNT_W-1:0]  w_clamp;
    logic        [IDX_W-1:0]  n1_next, n1_reg;
    logic                     full_next, full_reg;

    logic        [ENT_W-1:0]  ring_mem [MAX_WINDOW];
    logic        [ENT_W-1:0]  rd_data_reg;
    logic        [IDX_W-1:0]  rd_ptr_reg, rd_cnt_reg;
    logic                     rd_vld_reg;

    logic        [ACC_W-1:0]  new_r_reg, new_g_reg, new_b_reg;
    logic        [OLD_W-1:0]  old_r_reg, old_g_reg, old_b_reg;
    logic        [OLD_W-1:0]  prod_r_reg, prod_g_reg, prod_b_reg;
    logic signed [DW-1:0]     d_r_reg, d_g_reg, d_b_reg;
    logic signed [SW-1:0]     s_next, s_reg;
    logic signed [TW-1:0]     t_next, t_reg;
    logic signed [PLO_W-1:0]  p_lo_reg;
    logic signed [PHI_W-1:0]  p_hi_reg;
    logic signed [CW-1:0]     lhs_reg, rhs_reg;

    logic                     m_valid_reg;
    result_t                  m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wf_reg  <= WF_W'(DEF_WINDOW_FRAMES);
            thr_reg <= THR_W'(DEF_THRESHOLD_Q);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_FRAMES: begin
                    wf_reg <= cfg_data[WF_W-1:0];
                end
                REG_THRESHOLD_Q: begin
                    thr_reg <= $signed(cfg_data[THR_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    assign red_next   = sat_add(red_acc_reg, s_data.red);
    assign green_next = sat_add(green_acc_reg, s_data.green);
    assign blue_next  = sat_add(blue_acc_reg, s_data.blue);

    always_comb begin
        wf_ext = WCMP_W'(wf_reg);
        if (wf_ext < WCMP_W'(MIN_WINDOW)) begin
            w_clamp = CNT_W'(MIN_WINDOW);
        end else if (wf_ext > WCMP_W'(MAX_WINDOW)) begin
            w_clamp = CNT_W'(MAX_WINDOW);
        end else begin
            w_clamp = CNT_W'(wf_ext);
        end
    end

    assign fill_inc  = {1'b0, fill_reg} + (CNT_W + 1)'(1);
    assign fill_next = (fill_inc > {1'b0, w_clamp}) ? w_clamp : fill_inc[CNT_W-1:0];
    assign full_next = (fill_next == w_clamp);
    assign n1_next   = IDX_W'(w_clamp - CNT_W'(1));
    assign head_next = (head_reg == IDX_W'(MAX_WINDOW - 1)) ? '0 : head_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
        end else if (dp_cmd.clear) begin
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
            fill_reg      <= '0;
        end else if (dp_cmd.frame_end) begin
            red_acc_reg   <= '0;
            green_acc_reg <= '0;
            blue_acc_reg  <= '0;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
        end else if (dp_cmd.pixel) begin
            red_acc_reg   <= red_next;
            green_acc_reg <= green_next;
            blue_acc_reg  <= blue_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.frame_end) begin
            ring_mem[head_next] <= {blue_next, green_next, red_next};
        end
        rd_data_reg <= ring_mem[rd_ptr_reg];
    end

    // The sweep walks backwards from the previous newest slot over the older frames.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_cnt_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= (rd_cnt_reg != '0);
            if (dp_cmd.frame_end && full_next) begin
                rd_cnt_reg <= n1_next;
            end else if (rd_cnt_reg != '0) begin
                rd_cnt_reg <= rd_cnt_reg - IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.frame_end) begin
            rd_ptr_reg <= head_reg;
        end else if (rd_cnt_reg != '0) begin
            rd_ptr_reg <= (rd_ptr_reg == '0) ? IDX_W'(MAX_WINDOW - 1) : rd_ptr_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_r_reg <= '0;
            old_g_reg <= '0;
            old_b_reg <= '0;
            full_reg  <= 1'b0;
        end else if (dp_cmd.frame_end) begin
            old_r_reg <= '0;
            old_g_reg <= '0;
            old_b_reg <= '0;
            full_reg  <= full_next;
        end else if (rd_vld_reg) begin
            old_r_reg <= old_r_reg + OLD_W'(rd_data_reg[ACC_W-1:0]);
            old_g_reg <= old_g_reg + OLD_W'(rd_data_reg[2*ACC_W-1:ACC_W]);
            old_b_reg <= old_b_reg + OLD_W'(rd_data_reg[3*ACC_W-1:2*ACC_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.frame_end) begin
            new_r_reg <= red_next;
            new_g_reg <= green_next;
            new_b_reg <= blue_next;
            n1_reg    <= n1_next;
        end
    end

    assign s_next = $signed({d_g_reg[DW-1], d_g_reg}) + $signed({d_r_reg[DW-1], d_r_reg});
    assign t_next = $signed({d_b_reg[DW-1], d_b_reg, 1'b0}) - $signed({s_next[SW-1], s_next});

    // Arithmetic chain; the sums and n1 hold after the sweep, but thr_reg follows cfg writes.
    always_ff @(posedge aclk) begin
        prod_r_reg <= OLD_W'(new_r_reg) * OLD_W'(n1_reg);
        prod_g_reg <= OLD_W'(new_g_reg) * OLD_W'(n1_reg);
        prod_b_reg <= OLD_W'(new_b_reg) * OLD_W'(n1_reg);
        d_r_reg    <= $signed({1'b0, prod_r_reg}) - $signed({1'b0, old_r_reg});
        d_g_reg    <= $signed({1'b0, prod_g_reg}) - $signed({1'b0, old_g_reg});
        d_b_reg    <= $signed({1'b0, prod_b_reg}) - $signed({1'b0, old_b_reg});
        s_reg      <= s_next;
        t_reg      <= t_next;
        p_lo_reg   <= PLO_W'(thr_reg) * PLO_W'($signed({1'b0, s_reg[LO_W-1:0]}));
        p_hi_reg   <= PHI_W'(thr_reg) * PHI_W'($signed(s_reg[SW-1:LO_W]));
        lhs_reg    <= $signed({{(CW - TW - Q_FRAC){t_reg[TW-1]}}, t_reg, {Q_FRAC{1'b0}}});
        rhs_reg    <= $signed({p_hi_reg, {LO_W{1'b0}}})
                    + $signed({{(CW - PLO_W){p_lo_reg[PLO_W-1]}}, p_lo_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            m_data_reg.light_on    <= full_reg & (lhs_reg > rhs_reg);
            m_data_reg.window_full <= full_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_data             = m_data_reg;
    assign dp_stat.full_now   = full_next;
    assign dp_stat.sweep_busy = (rd_cnt_reg != '0) || rd_vld_reg;
    assign dp_stat.out_free   = !m_valid_reg || m_ready;

endmodule

`default_nettype wire

FILE: sv/fccd_ctrl.sv
// Controller: accepts beats, sequences the window sweep and the arithmetic, and loads the result.
`default_nettype none

module fccd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  fccd_pkg::pix_in_t  s_data,
    output logic               s_ready,
    output fccd_pkg::dp_cmd_t  dp_cmd,
    input  fccd_pkg::dp_stat_t dp_stat
);
    import fccd_pkg::*;

    localparam int LAT_W = $clog2(CALC_LAT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_CALC  = 2'd2;
    localparam logic [1:0] ST_LOAD  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [LAT_W-1:0] lat_reg, lat_next;
    logic             accept;

    assign accept           = s_valid && (state_reg == ST_IDLE);
    assign dp_cmd.clear     = accept && (s_data.cmd == CMD_CLEAR);
    assign dp_cmd.pixel     = accept && (s_data.cmd == CMD_PIXEL);
    assign dp_cmd.frame_end = dp_cmd.pixel && s_data.frame_end;
    assign dp_cmd.load      = (state_reg == ST_LOAD) && dp_stat.out_free;
    assign s_ready          = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        lat_next   = lat_reg;
        case (state_reg)
            ST_IDLE: begin
                if (dp_cmd.frame_end) begin
                    state_next = dp_stat.full_now ? ST_SWEEP : ST_LOAD;
                end
            end
            ST_SWEEP: begin
                if (!dp_stat.sweep_busy) begin
                    state_next = ST_CALC;
                    lat_next   = LAT_W'(CALC_LAT - 1);
                end
            end
            ST_CALC: begin
                if (lat_reg == '0) begin
                    state_next = ST_LOAD;
                end else begin
                    lat_next = lat_reg - LAT_W'(1);
                end
            end
            ST_LOAD: begin
                if (dp_stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            lat_reg   <= '0;
        end else begin
            state_reg <= state_next;
            lat_reg   <= lat_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/frame_color_change_detector.sv
// Top level of the frame colour change detector: controller, datapath and checks.
//
// Pixel beats enter on the s_ channel: cmd selects a pixel or a clear of the frame window,
// frame_end marks the last pixel of a frame. Only a frame-end pixel gives a result beat on
// the m_ channel, carrying light_on and window_full. Registers are written over the cfg_
// channel, which is always ready: index 0 is window_frames, index 1 is threshold_q.
// Pixels and clears are taken one per cycle while the controller is idle. A frame-end pixel with
// the window not yet full goes straight to loading its result; with the window full its w - 1
// older ring entries are first swept one per cycle through the single read port and the
// arithmetic chain runs, w being window_frames clamped to 2..MAX_WINDOW. Input is refused from
// the frame-end beat until the result has been loaded into the output register.
// A stalled receiver holds the result in that register; pixels keep flowing meanwhile and
// only the next frame-end result waits for it to drain.
// Reset clears the sums, the window and the registers to their defaults; the ring needs no
// clearing, as the fill count keeps unwritten entries from being read.
`default_nettype none

module frame_color_change_detector #(
    parameter int MAX_WINDOW        = fccd_pkg::DEF_MAX_WINDOW,
    parameter int FRAME_PIXELS_LOG2 = fccd_pkg::DEF_FRAME_PIXELS_LOG2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fccd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fccd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  fccd_pkg::pix_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output fccd_pkg::result_t               m_data
);
    import fccd_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    assign cfg_ready = 1'b1;

    fccd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .dp_cmd  (dp_cmd),
        .dp_stat (dp_stat)
    );

    fccd_dp #(
        .MAX_WINDOW        (MAX_WINDOW),
        .FRAME_PIXELS_LOG2 (FRAME_PIXELS_LOG2)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    a_load_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.load |-> dp_stat.out_free)
        else $error("result loaded while the output register still holds an untaken beat");

    a_busy_only_after_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(dp_cmd.frame_end))
        else $error("input stopped without a frame-end beat");

    a_no_input_during_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_stat.sweep_busy |-> !s_ready)
        else $error("input accepted while the window sweep is running");

endmodule

`default_nettype wire

FILE: tb/sv/frame_color_change_detector_tb.sv
// Self-checking testbench for the frame colour change detector with a cycle-free window predictor.
`timescale 1ns / 1ps

module frame_color_change_detector_tb;
    import fccd_pkg::*;

    localparam int ACC_W        = DEF_FRAME_PIXELS_LOG2 + COLOR_W;
    localparam int DRAIN_CYCLES = DEF_MAX_WINDOW + CALC_LAT + 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;

    typedef logic [ACC_W-1:0] chan_sum_t;
    localparam chan_sum_t ACC_MAX = '1;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pix_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    result_t               m_data;

    pix_in_t pending_beats[$];
    result_t expected_results[$];

    int send_idle_pct = 0;
    int rx_stall_pct  = 0;
    logic rx_hold_req = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int beats_queued   = 0;
    int beats_taken    = 0;
    int frames_closed  = 0;
    int clears_taken   = 0;
    int results_seen   = 0;
    int full_seen      = 0;
    int light_seen     = 0;
    int settings_used  = 0;
    int mismatch_count = 0;

    // Predictor state, kept in step with accepted beats and register writes.
    chan_sum_t               red_sum = '0, green_sum = '0, blue_sum = '0;
    chan_sum_t               red_hist[DEF_MAX_WINDOW];
    chan_sum_t               green_hist[DEF_MAX_WINDOW];
    chan_sum_t               blue_hist[DEF_MAX_WINDOW];
    int                      newest_slot = 0;
    int                      frames_held = 0;
    logic [WF_W-1:0]         window_reg  = WF_W'(DEF_WINDOW_FRAMES);
    logic signed [THR_W-1:0] thresh_reg  = THR_W'(DEF_THRESHOLD_Q);

    frame_color_change_detector i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial forever #5 aclk = ~aclk;

    function automatic chan_sum_t add_clipped(chan_sum_t acc, logic [COLOR_W-1:0] v);
        logic [ACC_W:0] total;
        total = {1'b0, acc} + (ACC_W + 1)'(v);
        return (total > {1'b0, ACC_MAX}) ? ACC_MAX : total[ACC_W-1:0];
    endfunction

    task automatic update_colour_window(input pix_in_t beat);
        int w, k, slot;
        longint old_r, old_g, old_b, dr, dg, db, s, lhs, rhs;
        result_t res;
        beats_taken++;
        if (beat.cmd == CMD_CLEAR) begin
            frames_held = 0;
            red_sum = '0;
            green_sum = '0;
            blue_sum = '0;
            clears_taken++;
            return;
        end
        red_sum = add_clipped(red_sum, beat.red);
        green_sum = add_clipped(green_sum, beat.green);
        blue_sum = add_clipped(blue_sum, beat.blue);
        if (!beat.frame_end) return;

        w = int'(window_reg);
        if (w < MIN_WINDOW) w = MIN_WINDOW;
        if (w > DEF_MAX_WINDOW) w = DEF_MAX_WINDOW;
        newest_slot = (newest_slot + 1) % DEF_MAX_WINDOW;
        red_hist[newest_slot] = red_sum;
        green_hist[newest_slot] = green_sum;
        blue_hist[newest_slot] = blue_sum;
        red_sum = '0;
        green_sum = '0;
        blue_sum = '0;
        frames_held = (frames_held + 1 > w) ? w : frames_held + 1;
        frames_closed++;

        res.window_full = (frames_held >= w);
        res.light_on = 1'b0;
        if (res.window_full) begin
            old_r = 0;
            old_g = 0;
            old_b = 0;
            for (k = 1; k < w; k++) begin
                slot = (newest_slot + DEF_MAX_WINDOW - k) % DEF_MAX_WINDOW;
                old_r += longint'(red_hist[slot]);
                old_g += longint'(green_hist[slot]);
                old_b += longint'(blue_hist[slot]);
            end
            dr = longint'(red_hist[newest_slot]) * (w - 1) - old_r;
            dg = longint'(green_hist[newest_slot]) * (w - 1) - old_g;
            db = longint'(blue_hist[newest_slot]) * (w - 1) - old_b;
            s = dg + dr;
            lhs = 256 * (2 * db - s);
            rhs = longint'(thresh_reg) * s;
            res.light_on = (lhs > rhs);
        end
        expected_results.push_back(res);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_FRAMES: begin
                        window_reg = cfg_data[WF_W-1:0];
                    end
                    REG_THRESHOLD_Q: begin
                        thresh_reg = cfg_data[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) update_colour_window(s_data);
            if (!s_valid || s_ready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= pending_beats.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : result_check
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.window_full) full_seen++;
                if (m_data.light_on) light_seen++;
                if (expected_results.size() == 0) begin
                    $error("Result beat with no frame end waiting: %p", m_data);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.light_on !== want.light_on) begin
                        $error("light_on: expected %0b, got %0b", want.light_on, m_data.light_on);
                        mismatch_count++;
                    end
                    if (m_data.window_full !== want.window_full) begin
                        $error("window_full: expected %0b, got %0b",
                               want.window_full, m_data.window_full);
                        mismatch_count++;
                    end
                end
            end
            if (rx_hold_req && hold_left == 0) begin
                hold_left <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
            m_ready <= (hold_left == 0) && !rx_hold_req && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic queue_beat(input logic cmd, input logic [COLOR_W-1:0] r, g, b,
                              input logic fe);
        pix_in_t beat;
        beat.cmd = cmd;
        beat.red = r;
        beat.green = g;
        beat.blue = b;
        beat.frame_end = fe;
        pending_beats.push_back(beat);
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly whole frames around a per-frame colour level, with clears and stray pixels mixed in.
    task automatic queue_traffic(input int n_beats, input int max_frame, input int clear_pct);
        int first, roll, len, k;
        logic [COLOR_W-1:0] lvl_r, lvl_g, lvl_b;
        first = beats_queued;
        while (beats_queued - first < n_beats) begin
            roll = $urandom_range(99);
            if (roll < clear_pct) begin
                queue_beat(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end else if (roll < clear_pct + 5) begin
                queue_beat(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end else begin
                len = ($urandom_range(9) == 0) ? $urandom_range(1, 12)
                                               : $urandom_range(1, max_frame);
                lvl_r = 8'($urandom);
                lvl_g = 8'($urandom);
                lvl_b = 8'($urandom);
                for (k = 1; k <= len; k++) begin
                    queue_beat(CMD_PIXEL,
                               ($urandom_range(3) == 0) ? 8'($urandom) : lvl_r,
                               ($urandom_range(3) == 0) ? 8'($urandom) : lvl_g,
                               ($urandom_range(3) == 0) ? 8'($urandom) : lvl_b,
                               k == len);
                end
            end
        end
    endtask

    task automatic run_phase(input logic [WF_W-1:0] win, input logic [THR_W-1:0] thr,
                             input int sidle, input int rstall, input int n_beats,
                             input int max_frame, input int clear_pct);
        wait_drained();
        write_reg(REG_WINDOW_FRAMES, CFG_DATA_W'(win));
        write_reg(REG_THRESHOLD_Q, CFG_DATA_W'(thr));
        settings_used++;
        send_idle_pct <= sidle;
        rx_stall_pct <= rstall;
        queue_traffic(n_beats, max_frame, clear_pct);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: an eight-frame window cannot be full after one frame.
        queue_beat(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        wait_drained();

        // A window size of zero is clamped to two frames.
        write_reg(REG_WINDOW_FRAMES, CFG_DATA_W'(0));
        settings_used++;
        queue_beat(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_beat(CMD_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1);
        queue_beat(CMD_PIXEL, 8'h00, 8'h00, 8'hFF, 1'b1);
        queue_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'h00, 1'b1);
        queue_beat(CMD_PIXEL, 8'h01, 8'h02, 8'h03, 1'b0);
        queue_beat(CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_beat(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        queue_beat(CMD_PIXEL, 8'h80, 8'h40, 8'hC8, 1'b0);
        queue_beat(CMD_PIXEL, 8'h7F, 8'hBF, 8'h37, 1'b1);
        queue_beat(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
        queue_beat(CMD_PIXEL, 8'hAA, 8'h55, 8'h0F, 1'b1);
        queue_beat(CMD_PIXEL, 8'h55, 8'hAA, 8'hF0, 1'b1);

        run_phase(7'd8, 16'sd256, 0, 0, 220, 4, 2);
        // Shrinking a full window keeps only the newest frames.
        run_phase(7'd3, 16'h8000, 70, 0, 200, 4, 3);
        run_phase(7'd127, 16'h7FFF, 0, 70, 260, 2, 0);
        run_phase(7'd1, 16'h0000, 38, 38, 180, 5, 4);

        run_phase(7'd4, 16'd128, 0, 0, 160, 3, 2);
        @(posedge aclk);
        rx_hold_req <= 1'b1;
        @(posedge aclk);
        rx_hold_req <= 1'b0;
        wait_drained();
        queue_traffic(100, 3, 2);

        run_phase(7'($urandom), 16'($urandom), 38, 38, 120, 4, 3);
        run_phase(7'($urandom), 16'($urandom), 38, 38, 120, 4, 3);
        wait_drained();

        $display("Run covered %0d beats: %0d frames, %0d clears, over %0d register settings.",
                 beats_taken, frames_closed, clears_taken, settings_used);
        $display("Checked %0d results, %0d with a full window and %0d with the light on.",
                 results_seen, full_seen, light_seen);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/fccd_pkg.sv
sv/fccd_dp.sv
sv/fccd_ctrl.sv
sv/frame_color_change_detector.sv
tb/sv/frame_color_change_detector_tb.sv
